// ===== rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion helpers shared by the RTL; they compile away when SYNTH is defined
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
// expression must hold at every clock edge out of reset
`define ASSERT_ALWAYS(label, clk, rst_n, expr, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);
// antecedent implies consequent in the same cycle
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);
`else
`define ASSERT_ALWAYS(label, clk, rst_n, expr, msg)
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg)
`endif

`endif

// ===== rtl/tol_pkg.sv =====
// ----------------------------------------------------------------------------
// tol_pkg
// Types and constants of the TCP option list checker
// ----------------------------------------------------------------------------
package tol_pkg;

	// walk phases
	localparam logic [1:0] PH_KIND = 2'd0;
	localparam logic [1:0] PH_LEN  = 2'd1;
	localparam logic [1:0] PH_BODY = 2'd2;

	// option kinds on the wire
	localparam logic [7:0] KIND_END    = 8'd0;
	localparam logic [7:0] KIND_NOP    = 8'd1;
	localparam logic [7:0] KIND_MSS    = 8'd2;
	localparam logic [7:0] KIND_WSCALE = 8'd3;
	localparam logic [7:0] KIND_SACKOK = 8'd4;
	localparam logic [7:0] KIND_SACK   = 8'd5;
	localparam logic [7:0] KIND_TSTAMP = 8'd8;
	localparam logic [7:0] KIND_UTO    = 8'd28;
	localparam logic [7:0] KIND_AO     = 8'd29;
	localparam logic [7:0] KIND_MPTCP  = 8'd30;

	// reported option codes
	localparam logic [3:0] OPT_NONE    = 4'd0;
	localparam logic [3:0] OPT_NOP     = 4'd1;
	localparam logic [3:0] OPT_MSS     = 4'd2;
	localparam logic [3:0] OPT_WSCALE  = 4'd3;
	localparam logic [3:0] OPT_SACKOK  = 4'd4;
	localparam logic [3:0] OPT_SACK    = 4'd5;
	localparam logic [3:0] OPT_TSTAMP  = 4'd6;
	localparam logic [3:0] OPT_UTO     = 4'd7;
	localparam logic [3:0] OPT_AO      = 4'd8;
	localparam logic [3:0] OPT_MPTCP   = 4'd9;
	localparam logic [3:0] OPT_UNKNOWN = 4'd10;

	// error codes
	localparam logic [2:0] ERR_OK      = 3'd0;
	localparam logic [2:0] ERR_BAD_LEN = 3'd1;
	localparam logic [2:0] ERR_NO_SYN  = 3'd2;
	localparam logic [2:0] ERR_PAST    = 3'd3;
	localparam logic [2:0] ERR_SHORT   = 3'd4;

	// data offset of a header with no option area
	localparam logic [3:0] BASE_WORDS = 4'd5;

	// walk state kept between bytes
	typedef struct packed {
		logic [1:0] phase;
		logic [7:0] held_kind;
		logic [7:0] body_left;
		logic [5:0] area_left;
		logic       syn_held;
		logic       failed;
	} tol_state_t;

	// one byte's outcome
	typedef struct packed {
		logic       emit;
		logic [3:0] option_code;
		logic [2:0] error_code;
		logic       list_end;
	} tol_result_t;

	// kind byte to reported option code
	function automatic logic [3:0] kind_code(input logic [7:0] kind);
		logic [3:0] code;
		case (kind)
			KIND_END:    code = OPT_NONE;
			KIND_NOP:    code = OPT_NOP;
			KIND_MSS:    code = OPT_MSS;
			KIND_WSCALE: code = OPT_WSCALE;
			KIND_SACKOK: code = OPT_SACKOK;
			KIND_SACK:   code = OPT_SACK;
			KIND_TSTAMP: code = OPT_TSTAMP;
			KIND_UTO:    code = OPT_UTO;
			KIND_AO:     code = OPT_AO;
			KIND_MPTCP:  code = OPT_MPTCP;
			default:     code = OPT_UNKNOWN;
		endcase
		return code;
	endfunction

endpackage

// ===== rtl/tol_step.sv =====
// ----------------------------------------------------------------------------
// tol_step
// Per-byte walk logic: next state and result for one option byte
// ----------------------------------------------------------------------------
module tol_step
	import tol_pkg::*;
(
	input  tol_state_t  state,
	input  logic [7:0]  opt_byte,
	input  logic        first_byte,
	input  logic [3:0]  header_words,
	input  logic        syn_set,
	output tol_state_t  state_next,
	output tol_result_t result
);

	tol_state_t base;
	logic [3:0] words_over;
	logic [5:0] area_dec;
	logic       last;
	logic       len_ok;
	logic       syn_needed;
	logic [2:0] len_err;
	logic [7:0] body_len;
	logic [7:0] body_dec;

	// segment start reload
	assign words_over = header_words - BASE_WORDS;

	always_comb begin
		base = state;
		if (first_byte) begin
			base.phase     = PH_KIND;
			base.held_kind = '0;
			base.body_left = '0;
			base.failed    = 1'b0;
			base.syn_held  = syn_set;
			base.area_left = (header_words > BASE_WORDS) ? {words_over, 2'b00} : '0;
		end
	end

	assign area_dec = base.area_left - 6'd1;
	assign last     = (area_dec == '0);
	assign body_len = opt_byte - 8'd2;
	assign body_dec = base.body_left - 8'd1;

	// length check for the held kind
	always_comb begin
		len_ok     = 1'b1;
		syn_needed = 1'b0;
		case (base.held_kind)
			KIND_MSS: begin
				len_ok     = (opt_byte == 8'd4);
				syn_needed = 1'b1;
			end
			KIND_WSCALE: begin
				len_ok     = (opt_byte == 8'd3);
				syn_needed = 1'b1;
			end
			KIND_SACKOK: begin
				len_ok     = (opt_byte == 8'd2);
				syn_needed = 1'b1;
			end
			KIND_SACK:   len_ok = opt_byte inside {8'd10, 8'd18, 8'd26, 8'd34};
			KIND_TSTAMP: len_ok = (opt_byte == 8'd10);
			KIND_UTO:    len_ok = (opt_byte == 8'd4);
			default:     len_ok = 1'b1;
		endcase
		if (opt_byte < 8'd2)
			len_err = ERR_SHORT;
		else if (!len_ok)
			len_err = ERR_BAD_LEN;
		else if (syn_needed && !base.syn_held)
			len_err = ERR_NO_SYN;
		else if (body_len > {2'b00, area_dec})
			len_err = ERR_PAST;
		else
			len_err = ERR_OK;
	end

	// walk one byte
	always_comb begin
		state_next         = base;
		result.emit        = 1'b0;
		result.option_code = OPT_NONE;
		result.error_code  = ERR_OK;
		result.list_end    = last;
		if (base.area_left != '0) begin
			state_next.area_left = area_dec;
			result.emit          = last;
			if (!base.failed) begin
				case (base.phase)
					PH_LEN: begin
						result.option_code = kind_code(base.held_kind);
						result.error_code  = len_err;
						if (len_err != ERR_OK) begin
							state_next.failed = 1'b1;
							state_next.phase  = PH_KIND;
							result.emit       = 1'b1;
						end else if (opt_byte == 8'd2) begin
							state_next.phase = PH_KIND;
							result.emit      = 1'b1;
						end else begin
							state_next.body_left = body_len;
							state_next.phase     = PH_BODY;
						end
					end
					PH_BODY: begin
						state_next.body_left = body_dec;
						if (body_dec == '0) begin
							result.option_code = kind_code(base.held_kind);
							result.emit        = 1'b1;
							state_next.phase   = PH_KIND;
						end
					end
					default: begin
						if (opt_byte == KIND_NOP) begin
							result.option_code = OPT_NOP;
							result.emit        = 1'b1;
						end else if (opt_byte != KIND_END) begin
							state_next.held_kind = opt_byte;
							if (last) begin
								result.option_code = kind_code(opt_byte);
								result.error_code  = ERR_PAST;
								result.emit        = 1'b1;
								state_next.failed  = 1'b1;
							end else begin
								state_next.phase = PH_LEN;
							end
						end
					end
				endcase
			end
		end
	end

endmodule

// ===== rtl/tol_out_reg.sv =====
// ----------------------------------------------------------------------------
// tol_out_reg
// Result register on the output channel
// ----------------------------------------------------------------------------
module tol_out_reg
	import tol_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        load,
	input  tol_result_t result,
	output logic        free,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [3:0]  option_code,
	output logic [2:0]  error_code,
	output logic        list_end
);

	logic       valid_q;
	logic [3:0] code_q;
	logic [2:0] err_q;
	logic       end_q;

	// register can take a result when empty or being drained
	assign free = !valid_q || out_ready;

	// valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_q <= 1'b0;
		else if (load)
			valid_q <= 1'b1;
		else if (out_ready)
			valid_q <= 1'b0;
	end

	// payload
	always_ff @(posedge clk) begin
		if (load) begin
			code_q <= result.option_code;
			err_q  <= result.error_code;
			end_q  <= result.list_end;
		end
	end

	assign out_valid   = valid_q;
	assign option_code = code_q;
	assign error_code  = err_q;
	assign list_end    = end_q;

endmodule

// ===== rtl/tcp_option_list_checker.sv =====
// ----------------------------------------------------------------------------
// tcp_option_list_checker
// Walks a TCP option area one byte per transfer and reports options/errors
// ----------------------------------------------------------------------------
//  channel | signals                                     | direction
//  in      | in_valid in_ready opt_byte first_byte       | into block
//          | header_words syn_set                        |
//  out     | out_valid out_ready option_code error_code  | out of block
//          | list_end                                    |
//
//  One byte per cycle sustained unless a held result stalls the byte register.
//  The byte register feeds the walk logic, whose result lands in the output register.
//  A held result stalls the byte register only when a new result must be written.
//  Reset clears the walk state and both valid flags; no clearing pass.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module tcp_option_list_checker
	import tol_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] opt_byte,
	input  logic       first_byte,
	input  logic [3:0] header_words,
	input  logic       syn_set,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [3:0] option_code,
	output logic [2:0] error_code,
	output logic       list_end
);

	logic        valid_s1;
	logic [7:0]  byte_s1;
	logic        first_s1;
	logic [3:0]  words_s1;
	logic        syn_s1;
	tol_state_t  state_q;
	tol_state_t  state_next;
	tol_result_t result;
	logic        out_free;
	logic        advance;

	// byte leaves stage 1 unless its result cannot be stored
	assign advance  = valid_s1 && (out_free || !result.emit);
	assign in_ready = !valid_s1 || advance;

	// input byte register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else if (in_ready)
			valid_s1 <= in_valid;
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			byte_s1  <= opt_byte;
			first_s1 <= first_byte;
			words_s1 <= header_words;
			syn_s1   <= syn_set;
		end
	end

	// walk logic
	tol_step u_step (
		.state        (state_q),
		.opt_byte     (byte_s1),
		.first_byte   (first_s1),
		.header_words (words_s1),
		.syn_set      (syn_s1),
		.state_next   (state_next),
		.result       (result)
	);

	// walk state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '{phase: PH_KIND, held_kind: '0, body_left: '0,
				area_left: '0, syn_held: 1'b0, failed: 1'b0};
		end else if (advance) begin
			state_q <= state_next;
		end
	end

	// result register
	tol_out_reg u_out (
		.clk         (clk),
		.arst_n      (arst_n),
		.load        (advance && result.emit),
		.result      (result),
		.free        (out_free),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.option_code (option_code),
		.error_code  (error_code),
		.list_end    (list_end)
	);

	// checks
	`ASSERT_IMPLY(a_err_has_kind, clk, arst_n, out_valid && (error_code != ERR_OK), option_code >= OPT_MSS, "error reported without an option kind")
	`ASSERT_IMPLY(a_area_done_kind, clk, arst_n, state_q.area_left == '0, state_q.phase == PH_KIND, "area exhausted mid-option")
	`ASSERT_IMPLY(a_body_fits, clk, arst_n, (state_q.phase == PH_BODY) && !state_q.failed, state_q.body_left <= {2'b00, state_q.area_left}, "option body runs past area")
	`ASSERT_IMPLY(a_ready_when_empty, clk, arst_n, !out_valid, in_ready, "input stalled with empty result register")

endmodule

// ===== tb/sv/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for tcp_option_list_checker: option areas, mostly
// well-formed with random content plus corrupted and cut-short lists, are
// streamed in a byte per transfer while a software walk of the same list
// predicts every report and compares it with the block's output
// ----------------------------------------------------------------------------
import tol_pkg::*;

// one report of the walk
typedef struct packed {
	logic [3:0] option_code;
	logic [2:0] error_code;
	logic       list_end;
} option_report_t;

// walk of the option list and queue of the reports it predicts
class option_report_board;
	logic [1:0]     phase;
	logic [7:0]     held_kind;
	logic [7:0]     body_left;
	logic [5:0]     area_left;
	logic           syn_held;
	logic           failed;
	option_report_t due_reports[$];
	int             mismatches;
	int             reports_seen;

	function new();
		clear_walk();
		mismatches = 0;
		reports_seen = 0;
	endfunction

	function void clear_walk();
		phase = PH_KIND;
		held_kind = '0;
		body_left = '0;
		area_left = '0;
		syn_held = 1'b0;
		failed = 1'b0;
	endfunction

	// reported code of a wire kind
	function logic [3:0] code_for_kind(logic [7:0] kind);
		case (kind)
			KIND_END:    return OPT_NONE;
			KIND_NOP:    return OPT_NOP;
			KIND_MSS:    return OPT_MSS;
			KIND_WSCALE: return OPT_WSCALE;
			KIND_SACKOK: return OPT_SACKOK;
			KIND_SACK:   return OPT_SACK;
			KIND_TSTAMP: return OPT_TSTAMP;
			KIND_UTO:    return OPT_UTO;
			KIND_AO:     return OPT_AO;
			KIND_MPTCP:  return OPT_MPTCP;
			default:     return OPT_UNKNOWN;
		endcase
	endfunction

	// verdict on a length byte, checks in priority order
	function logic [2:0] length_verdict(logic [7:0] kind, logic [7:0] len);
		bit syn_only;
		bit fits_kind;
		syn_only = 1'b0;
		fits_kind = 1'b1;
		if (len < 8'd2)
			return ERR_SHORT;
		case (kind)
			KIND_MSS: begin
				fits_kind = (len == 8'd4);
				syn_only = 1'b1;
			end
			KIND_WSCALE: begin
				fits_kind = (len == 8'd3);
				syn_only = 1'b1;
			end
			KIND_SACKOK: begin
				fits_kind = (len == 8'd2);
				syn_only = 1'b1;
			end
			KIND_SACK: fits_kind = (len == 8'd10 || len == 8'd18 || len == 8'd26 ||
				len == 8'd34);
			KIND_TSTAMP: fits_kind = (len == 8'd10);
			KIND_UTO:    fits_kind = (len == 8'd4);
			default:     fits_kind = 1'b1;
		endcase
		if (!fits_kind)
			return ERR_BAD_LEN;
		if (syn_only && !syn_held)
			return ERR_NO_SYN;
		if (int'(len) - 2 > int'(area_left))
			return ERR_PAST;
		return ERR_OK;
	endfunction

	// advance the walk by one accepted byte
	function void note_byte(logic [7:0] data, logic first, logic [3:0] words, logic syn);
		option_report_t rep;
		bit             last;
		bit             emit;
		rep = '0;
		if (first) begin
			clear_walk();
			syn_held = syn;
			area_left = (words > BASE_WORDS) ?
				6'((int'(words) - int'(BASE_WORDS)) * 4) : 6'd0;
		end
		if (area_left == 6'd0)
			return;
		area_left = area_left - 6'd1;
		last = (area_left == 6'd0);
		emit = last;
		if (!failed) begin
			case (phase)
				PH_LEN: begin
					rep.option_code = code_for_kind(held_kind);
					rep.error_code = length_verdict(held_kind, data);
					if (rep.error_code != ERR_OK) begin
						failed = 1'b1;
						emit = 1'b1;
						phase = PH_KIND;
					end else if (data == 8'd2) begin
						emit = 1'b1;
						phase = PH_KIND;
					end else begin
						body_left = data - 8'd2;
						phase = PH_BODY;
					end
				end
				PH_BODY: begin
					body_left = body_left - 8'd1;
					if (body_left == 8'd0) begin
						rep.option_code = code_for_kind(held_kind);
						emit = 1'b1;
						phase = PH_KIND;
					end
				end
				default: begin
					if (data == KIND_NOP) begin
						rep.option_code = OPT_NOP;
						emit = 1'b1;
					end else if (data != KIND_END) begin
						held_kind = data;
						// a multi-byte kind cannot start on the last byte
						if (last) begin
							rep.option_code = code_for_kind(data);
							rep.error_code = ERR_PAST;
							failed = 1'b1;
							emit = 1'b1;
						end else begin
							phase = PH_LEN;
						end
					end
				end
			endcase
		end
		if (emit) begin
			rep.list_end = last;
			due_reports = {due_reports, rep};
		end
	endfunction

	// compare one output transfer with the oldest prediction
	function void check_report(logic [3:0] code, logic [2:0] err, logic last);
		option_report_t want;
		reports_seen++;
		if (due_reports.size() == 0) begin
			$display("%0t: report with none pending: option_code %0d error_code %0d list_end %0d",
				$time, code, err, last);
			mismatches++;
			return;
		end
		want = due_reports.pop_front();
		if (code !== want.option_code) begin
			$display("%0t: option_code expected %0d, actual %0d", $time, want.option_code, code);
			mismatches++;
		end
		if (err !== want.error_code) begin
			$display("%0t: error_code expected %0d, actual %0d", $time, want.error_code, err);
			mismatches++;
		end
		if (last !== want.list_end) begin
			$display("%0t: list_end expected %0d, actual %0d", $time, want.list_end, last);
			mismatches++;
		end
	endfunction
endclass

module tb;
	localparam int RANDOM_BYTES = 1230;
	localparam int CYCLE_LIMIT  = 200000;

	logic       clk;
	logic       arst_n;
	logic       in_valid;
	logic       in_ready;
	logic [7:0] opt_byte;
	logic       first_byte;
	logic [3:0] header_words;
	logic       syn_set;
	logic       out_valid;
	logic       out_ready;
	logic [3:0] option_code;
	logic [2:0] error_code;
	logic       list_end;

	option_report_board option_board;
	logic [7:0]         area_bytes[$];
	int                 len_at[$];
	bit                 gaps_on;
	bit                 stall_on;
	int                 bytes_sent;
	int                 segments;
	int                 cycle_count = 0;

	tcp_option_list_checker dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.opt_byte(opt_byte),
		.first_byte(first_byte),
		.header_words(header_words),
		.syn_set(syn_set),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.option_code(option_code),
		.error_code(error_code),
		.list_end(list_end)
	);

	// clock
	initial clk = 1'b0;
	always #2 clk = ~clk;

	// run limit
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycle_count);
			$display("Mismatches found");
			$finish;
		end
	end

	// receiver back-pressure
	always @(posedge clk) begin
		out_ready <= !stall_on || ($urandom_range(0, 99) >= 10);
	end

	// observe both channels
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && in_ready)
				option_board.note_byte(opt_byte, first_byte, header_words, syn_set);
			if (out_valid && out_ready)
				option_board.check_report(option_code, error_code, list_end);
		end
	end

	// one byte transfer, with an occasional gap before it
	task automatic send_byte(logic [7:0] data, logic first, logic [3:0] words, logic syn);
		if (gaps_on && $urandom_range(0, 99) < 10) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 3)) @(posedge clk);
		end
		in_valid <= 1'b1;
		opt_byte <= data;
		first_byte <= first;
		header_words <= words;
		syn_set <= syn;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
	endtask

	// first count bytes of area_bytes as one segment; unread fields get noise
	task automatic send_area(logic [3:0] words, logic syn, int count);
		segments++;
		for (int i = 0; i < count; i++) begin
			if (i == 0)
				send_byte(area_bytes[i], 1'b1, words, syn);
			else
				send_byte(area_bytes[i], 1'b0, 4'($urandom_range(6, 15)),
					1'($urandom_range(0, 1)));
			bytes_sent++;
		end
	endtask

	// stray byte with no area open
	task automatic send_stray();
		send_byte(8'($urandom_range(0, 255)), 1'b0, 4'($urandom_range(6, 15)),
			1'($urandom_range(0, 1)));
	endtask

	// hold off the sender until every report is out
	task automatic wait_for_reports();
		in_valid <= 1'b0;
		@(posedge clk);
		while (option_board.due_reports.size() != 0) @(posedge clk);
	endtask

	function automatic logic [7:0] pick_kind();
		logic [7:0] kind;
		case ($urandom_range(0, 10))
			0:       kind = KIND_END;
			1:       kind = KIND_NOP;
			2:       kind = KIND_MSS;
			3:       kind = KIND_WSCALE;
			4:       kind = KIND_SACKOK;
			5:       kind = KIND_SACK;
			6:       kind = KIND_TSTAMP;
			7:       kind = KIND_UTO;
			8:       kind = KIND_AO;
			9:       kind = KIND_MPTCP;
			default: begin
				do kind = 8'($urandom_range(0, 255));
				while (kind <= KIND_SACK || kind == KIND_TSTAMP ||
					(kind >= KIND_UTO && kind <= KIND_MPTCP));
			end
		endcase
		return kind;
	endfunction

	// well-formed option list filling size bytes, random content
	function automatic void compose_area(int size, logic syn);
		logic [7:0] kind;
		int         len;
		area_bytes.delete();
		len_at.delete();
		while (area_bytes.size() < size) begin
			kind = pick_kind();
			// without SYN the SYN-only kinds are mostly left out
			if (!syn && (kind == KIND_MSS || kind == KIND_WSCALE || kind == KIND_SACKOK) &&
				$urandom_range(0, 3) != 0)
				kind = KIND_NOP;
			case (kind)
				KIND_END, KIND_NOP: len = 1;
				KIND_MSS, KIND_UTO: len = 4;
				KIND_WSCALE:        len = 3;
				KIND_SACKOK:        len = 2;
				KIND_TSTAMP:        len = 10;
				KIND_SACK:          len = 10 + 8 * $urandom_range(0, 3);
				default:            len = $urandom_range(2, 14);
			endcase
			if (len > size - area_bytes.size()) begin
				area_bytes = {area_bytes, ($urandom_range(0, 1) ? KIND_NOP : KIND_END)};
			end else begin
				area_bytes = {area_bytes, kind};
				if (len > 1) begin
					len_at = {len_at, area_bytes.size()};
					area_bytes = {area_bytes, 8'(len)};
					for (int i = 2; i < len; i++)
						area_bytes = {area_bytes, 8'($urandom_range(0, 255))};
				end
			end
		end
	endfunction

	// stimulus
	initial begin
		logic [3:0] words;
		logic       syn;
		int         size;
		int         flavor;
		bit         drained;
		option_board = new();
		drained = 1'b0;
		bytes_sent = 0;
		segments = 0;
		gaps_on = 1'b1;
		stall_on = 1'b1;
		arst_n <= 1'b0;
		in_valid <= 1'b0;
		opt_byte <= 8'd0;
		first_byte <= 1'b0;
		header_words <= 4'd6;
		syn_set <= 1'b0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// good mss filling the whole area
		area_bytes = {KIND_MSS, 8'd4, 8'h05, 8'hB4};
		send_area(4'd6, 1'b1, 4);
		// nop, end padding, then a kind on the last byte
		area_bytes = {KIND_NOP, KIND_END, KIND_NOP, 8'hFF};
		send_area(4'd6, 1'b0, 4);
		// sack-permitted, then a length below two
		area_bytes = {KIND_SACKOK, 8'd2, KIND_SACK, 8'd1};
		send_area(4'd6, 1'b1, 4);
		// timestamp running past the area, rest ignored
		area_bytes = {KIND_TSTAMP, 8'd10, 8'h00, 8'hFF};
		send_area(4'd6, 1'b1, 4);
		// stray byte outside any area
		send_byte(8'h5A, 1'b0, 4'd15, 1'b1);
		// window scale without SYN in the largest area, cut short by a new segment
		area_bytes = {KIND_WSCALE, 8'd3};
		send_area(4'd15, 1'b0, 2);
		// user timeout with a bad length
		area_bytes = {KIND_UTO, 8'd5, 8'h00, 8'h00};
		send_area(4'd6, 1'b0, 4);

		// random segments
		while (bytes_sent < RANDOM_BYTES) begin
			gaps_on = !(bytes_sent >= 400 && bytes_sent < 650);
			stall_on = gaps_on;
			if (!drained && bytes_sent >= 800) begin
				wait_for_reports();
				drained = 1'b1;
			end
			words = 4'($urandom_range(6, 15));
			syn = ($urandom_range(0, 3) != 0);
			size = (int'(words) - int'(BASE_WORDS)) * 4;
			compose_area(size, syn);
			flavor = $urandom_range(0, 99);
			if (flavor >= 70 && flavor < 78) begin
				// one byte corrupted
				area_bytes[$urandom_range(0, size - 1)] = 8'($urandom_range(0, 255));
			end else if (flavor >= 78 && flavor < 86 && len_at.size() != 0) begin
				// a length byte made small
				area_bytes[len_at[$urandom_range(0, len_at.size() - 1)]] =
					8'($urandom_range(0, 12));
			end else if (flavor >= 86 && flavor < 91) begin
				// pure noise
				foreach (area_bytes[i])
					area_bytes[i] = 8'($urandom_range(0, 255));
			end
			if (flavor >= 91 && flavor < 96) begin
				send_area(words, syn, $urandom_range(1, size - 1));
			end else begin
				send_area(words, syn, size);
				if (flavor >= 96)
					repeat ($urandom_range(1, 3)) send_stray();
			end
		end

		// drain and let any stray report show up
		in_valid <= 1'b0;
		while (option_board.due_reports.size() != 0) @(posedge clk);
		repeat (10) @(posedge clk);

		$display("walked %0d option bytes in %0d segments, %0d reports compared",
			bytes_sent, segments, option_board.reports_seen);
		if (option_board.mismatches == 0 && option_board.due_reports.size() == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end
endmodule

// ===== files.f =====
+incdir+rtl
rtl/tol_pkg.sv
rtl/tol_step.sv
rtl/tol_out_reg.sv
rtl/tcp_option_list_checker.sv
tb/sv/tb.sv
